[hw/rtl/qcrd_pkg.sv]
`default_nettype none

package qcrd_pkg;

  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_MAX_DEPTH      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ISO_VALUE      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROOT_SIZE      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_FEATURE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WALL_FACTOR    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ADAPTIVE       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CURV_THRESHOLD = 3'd6;

  localparam logic [4:0]  MAX_DEPTH_RESET = 5'd8;
  localparam logic [30:0] ROOT_SIZE_RESET = 31'h0001_0000;
  localparam logic [31:0] Q_ONE           = 32'h0001_0000;

  localparam logic [3:0] MASK_NONE = 4'h0;
  localparam logic [3:0] MASK_ALL  = 4'hF;

endpackage

`default_nettype wire

[hw/rtl/quadtree_cell_refine_decision.sv]
`default_nettype none

// Decides for each quadtree cell request whether the cell should be subdivided. One request
// is accepted per clock while cell_stall is low; each decision passes through an input
// register, a distance/edge stage, a multiply stage (corner distance squared, cell size
// squared, scaled feature size) and the result register. Each stage holds its request only
// while the stage below it is full and stalled, so requests keep flowing while a finished
// decision waits. The user must write configuration through the APB port only while no
// request is in flight (not enforced); distances and sizes are Q16.16, comparisons exact.
module quadtree_cell_refine_decision #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                                            clk,
  input  wire                                            rst,
  input  wire                                            psel,
  input  wire                                            penable,
  input  wire                                            pwrite,
  input  wire  [((VALUE_BITS > 32) ? 3 : 2) + 2:0]       paddr,
  input  wire  [((VALUE_BITS > 32) ? 64 : 32)-1:0]       pwdata,
  output logic [((VALUE_BITS > 32) ? 64 : 32)-1:0]       prdata,
  output logic                                           pready,
  input  wire                                            cell_valid,
  output logic                                           cell_stall,
  input  wire  [4:0]                                     cell_depth,
  input  wire                                            is_leaf_cell,
  input  wire                                            crosses_surface,
  input  wire  signed [VALUE_BITS-1:0]                   corner_a,
  input  wire  signed [VALUE_BITS-1:0]                   corner_b,
  input  wire  signed [VALUE_BITS-1:0]                   corner_c,
  input  wire  signed [VALUE_BITS-1:0]                   corner_d,
  input  wire  [3:0]                                     sign_mask,
  output logic                                           decision_valid,
  input  wire                                            decision_stall,
  output logic                                           split_cell
);

  localparam int unsigned PW       = (VALUE_BITS > 32) ? 64 : 32;
  localparam int unsigned ADDR_LSB = (VALUE_BITS > 32) ? 3 : 2;
  localparam int unsigned DW       = VALUE_BITS + 1;
  localparam int unsigned MW       = (DW > 32) ? DW : 33;
  localparam int unsigned CW       = (DW > 31) ? DW : 31;

  function automatic logic [DW-1:0] abs_diff(input logic signed [VALUE_BITS-1:0] x,
                                             input logic signed [VALUE_BITS-1:0] y);
    logic signed [DW-1:0] d;
    d = DW'(x) - DW'(y);
    return d[DW-1] ? $unsigned(-d) : $unsigned(d);
  endfunction

  // configuration registers
  logic [4:0]            max_depth;
  logic [VALUE_BITS-1:0] iso_value;
  logic [30:0]           root_size;
  logic [30:0]           min_feature_size;
  logic [31:0]           wall_factor;
  logic                  adaptive_enable;
  logic [30:0]           curvature_threshold;

  logic [qcrd_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           reg_write;

  assign reg_idx   = paddr[ADDR_LSB +: qcrd_pkg::REG_IDX_W];
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth           <= qcrd_pkg::MAX_DEPTH_RESET;
      iso_value           <= '0;
      root_size           <= qcrd_pkg::ROOT_SIZE_RESET;
      min_feature_size    <= '0;
      wall_factor         <= qcrd_pkg::Q_ONE;
      adaptive_enable     <= 1'b0;
      curvature_threshold <= '0;
    end else if (reg_write) begin
      case (reg_idx)
        qcrd_pkg::REG_MAX_DEPTH:      max_depth           <= pwdata[4:0];
        qcrd_pkg::REG_ISO_VALUE:      iso_value           <= pwdata[VALUE_BITS-1:0];
        qcrd_pkg::REG_ROOT_SIZE:      root_size           <= pwdata[30:0];
        qcrd_pkg::REG_MIN_FEATURE:    min_feature_size    <= pwdata[30:0];
        qcrd_pkg::REG_WALL_FACTOR:    wall_factor         <= pwdata[31:0];
        qcrd_pkg::REG_ADAPTIVE:       adaptive_enable     <= pwdata[0];
        qcrd_pkg::REG_CURV_THRESHOLD: curvature_threshold <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qcrd_pkg::REG_MAX_DEPTH:      prdata = PW'(max_depth);
      qcrd_pkg::REG_ISO_VALUE:      prdata = PW'(iso_value);
      qcrd_pkg::REG_ROOT_SIZE:      prdata = PW'(root_size);
      qcrd_pkg::REG_MIN_FEATURE:    prdata = PW'(min_feature_size);
      qcrd_pkg::REG_WALL_FACTOR:    prdata = PW'(wall_factor);
      qcrd_pkg::REG_ADAPTIVE:       prdata = PW'(adaptive_enable);
      qcrd_pkg::REG_CURV_THRESHOLD: prdata = PW'(curvature_threshold);
      default:                      prdata = '0;
    endcase
  end

  // stage enables, each stage loads when empty or draining
  logic a_valid, b_valid, c_valid;
  logic en_a, en_b, en_c, en_out;

  assign en_out     = !decision_valid || !decision_stall;
  assign en_c       = !c_valid || en_out;
  assign en_b       = !b_valid || en_c;
  assign en_a       = !a_valid || en_b;
  assign cell_stall = !en_a;

  // input register
  logic [4:0]                   a_depth;
  logic                         a_leaf;
  logic                         a_cross;
  logic signed [VALUE_BITS-1:0] a_ca, a_cb, a_cc, a_cd;
  logic [3:0]                   a_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_depth <= cell_depth;
      a_leaf  <= is_leaf_cell;
      a_cross <= crosses_surface;
      a_ca    <= corner_a;
      a_cb    <= corner_b;
      a_cc    <= corner_c;
      a_cd    <= corner_d;
      a_mask  <= sign_mask;
    end
  end

  // distance and edge stage
  logic [DW-1:0] dist_a, dist_b, dist_c, dist_d, dist_ab, dist_cd, dist_min;
  logic [MW-1:0] dist_ext;

  assign dist_a   = abs_diff(a_ca, iso_value);
  assign dist_b   = abs_diff(a_cb, iso_value);
  assign dist_c   = abs_diff(a_cc, iso_value);
  assign dist_d   = abs_diff(a_cd, iso_value);
  assign dist_ab  = (dist_b < dist_a) ? dist_b : dist_a;
  assign dist_cd  = (dist_d < dist_c) ? dist_d : dist_c;
  assign dist_min = (dist_cd < dist_ab) ? dist_cd : dist_ab;
  assign dist_ext = MW'(dist_min);

  logic          b_pre_zero, b_skip_test, b_all_eq, b_m_big, b_curv_mask;
  logic [31:0]   b_m_lo;
  logic [30:0]   b_cell;
  logic [DW-1:0] b_e0, b_e1, b_e2, b_e3;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_pre_zero  <= (a_depth >= max_depth) || !a_leaf;
      b_skip_test <= !a_cross;
      b_all_eq    <= (a_ca == a_cb) && (a_cb == a_cc) && (a_cc == a_cd);
      b_m_big     <= |dist_ext[MW-1:32];
      b_m_lo      <= dist_ext[31:0];
      b_cell      <= root_size >> a_depth;
      b_e0        <= abs_diff(a_cb, a_ca);
      b_e1        <= abs_diff(a_cc, a_cb);
      b_e2        <= abs_diff(a_cd, a_cc);
      b_e3        <= abs_diff(a_ca, a_cd);
      b_curv_mask <= (a_mask != qcrd_pkg::MASK_NONE) && (a_mask != qcrd_pkg::MASK_ALL);
    end
  end

  // multiply and curvature stage
  logic [31:0]   wall_clamped;
  logic [DW-1:0] e_hi01, e_hi23, e_lo01, e_lo23, e_hi, e_lo, e_spread;

  assign wall_clamped = (wall_factor < qcrd_pkg::Q_ONE) ? qcrd_pkg::Q_ONE : wall_factor;
  assign e_hi01   = (b_e1 > b_e0) ? b_e1 : b_e0;
  assign e_lo01   = (b_e1 < b_e0) ? b_e1 : b_e0;
  assign e_hi23   = (b_e3 > b_e2) ? b_e3 : b_e2;
  assign e_lo23   = (b_e3 < b_e2) ? b_e3 : b_e2;
  assign e_hi     = (e_hi23 > e_hi01) ? e_hi23 : e_hi01;
  assign e_lo     = (e_lo23 < e_lo01) ? e_lo23 : e_lo01;
  assign e_spread = e_hi - e_lo;

  logic        c_pre_zero, c_skip_test, c_all_eq, c_m_big, c_high_curv;
  logic [63:0] c_m_sq;
  logic [61:0] c_cell_sq;
  logic [30:0] c_cell;
  logic [62:0] c_feature;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_pre_zero  <= b_pre_zero;
      c_skip_test <= b_skip_test;
      c_all_eq    <= b_all_eq;
      c_m_big     <= b_m_big;
      c_m_sq      <= 64'(b_m_lo) * 64'(b_m_lo);
      c_cell_sq   <= 62'(b_cell) * 62'(b_cell);
      c_cell      <= b_cell;
      c_feature   <= 63'(min_feature_size) * 63'(wall_clamped);
      c_high_curv <= b_curv_mask && (CW'(e_spread) > CW'(curvature_threshold));
    end
  end

  // result stage
  logic diag_far, size_small, split_next;

  assign diag_far   = c_m_big || (c_m_sq >= {1'b0, c_cell_sq, 1'b0});
  assign size_small = {16'd0, c_cell, 16'd0} <= c_feature;

  always_comb begin
    if (c_pre_zero) begin
      split_next = 1'b0;
    end else if (c_skip_test && (c_all_eq || diag_far)) begin
      split_next = 1'b0;
    end else if ((min_feature_size != '0) && size_small) begin
      split_next = adaptive_enable && c_high_curv;
    end else begin
      split_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decision_valid <= 1'b0;
    end else if (en_out) begin
      decision_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      split_cell <= split_next;
    end
  end

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    cell_stall |-> (a_valid && b_valid && c_valid && decision_valid))
    else $error("request stalled with an empty stage");

  a_prezero_no_split : assert property (@(posedge clk) disable iff (rst)
    (en_out && c_valid && c_pre_zero) |=> (decision_valid && !split_cell))
    else $error("split issued past depth limit or for non-leaf");

  a_depth_zero : assert property (@(posedge clk) disable iff (rst)
    (decision_valid && (max_depth == '0)) |-> !split_cell)
    else $error("split issued with zero max depth");

  a_drain_moves : assert property (@(posedge clk) disable iff (rst)
    (c_valid && en_out) |=> decision_valid)
    else $error("decision lost between multiply and result stage");

endmodule

`default_nettype wire
